@@ src/idkht_pkg.sv @@
// Shared types and constants for the id-keyed handle table.
package idkht_pkg;

	localparam int SLOT_COUNT_DEF = 31;
	localparam int KEY_W          = 16;
	localparam int VALUE_W        = 32;
	localparam int FLAGS_W        = 7;
	localparam int MARK_W         = FLAGS_W + 1;
	localparam int MARK_ACTIVE    = MARK_W - 1;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_REG    = 2'd1,
		KIND_UNREG  = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [MARK_W-1:0]  mark;
	} slot_entry_t;

	// kv_en writes key and value, mark_en writes the mark byte
	typedef struct packed {
		logic        kv_en;
		logic        mark_en;
		slot_entry_t entry;
	} slot_wr_t;

endpackage

@@ src/idkht_req_if.sv @@
// Request channel: kind, id, value and flags with valid/ready.
interface idkht_req_if
	import idkht_pkg::*;
	();
	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [KEY_W-1:0]    id;
	logic [VALUE_W-1:0]  value;
	logic [FLAGS_W-1:0]  flags;

	modport source (output valid, kind, id, value, flags, input ready);
	modport sink   (input valid, kind, id, value, flags, output ready);
endinterface

@@ src/idkht_rsp_if.sv @@
// Response channel: hit and data with valid/ready.
interface idkht_rsp_if
	import idkht_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [VALUE_W-1:0]  data;

	modport source (output valid, hit, data, input ready);
	modport sink   (input valid, hit, data, output ready);
endinterface

@@ src/idkht_slot_mem.sv @@
// Slot storage: key, value and mark arrays, one write port, one registered read port.
module idkht_slot_mem
	import idkht_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output slot_entry_t       rd_data,
	input  logic [IDX_W-1:0]  wr_addr,
	input  slot_wr_t          wr
);

	logic [KEY_W-1:0]   key_mem   [SLOT_COUNT];
	logic [VALUE_W-1:0] value_mem [SLOT_COUNT];
	logic [MARK_W-1:0]  mark_mem  [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr.kv_en) begin
			key_mem[wr_addr]   <= wr.entry.key;
			value_mem[wr_addr] <= wr.entry.value;
		end
		if (wr.mark_en) begin
			mark_mem[wr_addr] <= wr.entry.mark;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.key   <= key_mem[rd_addr];
			rd_data.value <= value_mem[rd_addr];
			rd_data.mark  <= mark_mem[rd_addr];
		end
	end

endmodule

@@ src/id_keyed_handle_table.sv @@
// Id-keyed handle table: request sequencer, slot scan and response register.
//
// One request channel (kind, id, value, flags) and one response channel
// (hit, data), both valid/ready; a transfer happens when both are high.
// Every request gives exactly one response.
// The table takes one request at a time: ready is high only while the
// sequencer is idle. Register, unregister and lookup scan the slots
// below the in-use count, one slot read per cycle through the single read
// port of the slot memory; a scan reads at most SLOT_COUNT slots.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the following request finishes its scan and
// then holds until the earlier response has been taken.
// Reset clears the in-use count, the sequencer and the response valid; slot
// contents are not cleared and only slots below the count are ever read.
module id_keyed_handle_table
	import idkht_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	idkht_req_if.sink   req,
	idkht_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic                cmp_vld_q;
	logic [IDX_W-1:0]    cmp_idx_q;
	kind_t               kind_q;
	logic [KEY_W-1:0]    id_q;
	logic [VALUE_W-1:0]  value_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic                out_valid_q;
	logic                hit_q;
	logic [VALUE_W-1:0]  data_q;

	slot_entry_t         rd_data;
	slot_wr_t            wr;
	logic [IDX_W-1:0]    wr_addr;

	logic                scanning;
	logic                more;
	logic                cmp_match;
	logic                done;
	logic                finish;
	logic                issue;
	logic                room;
	logic                hit_d;
	logic [VALUE_W-1:0]  data_d;
	logic                accept;

	assign accept   = req.valid && req.ready;
	assign scanning = (state_q == ST_SCAN);
	assign more     = (idx_q < cnt_q);
	assign room     = (cnt_q < CNT_W'(SLOT_COUNT));

	// shared compare: free slot for register, active key match otherwise
	always_comb begin
		cmp_match = 1'b0;
		if (cmp_vld_q) begin
			if (kind_q == KIND_REG) begin
				cmp_match = !rd_data.mark[MARK_ACTIVE];
			end else begin
				cmp_match = rd_data.mark[MARK_ACTIVE] && (rd_data.key == id_q);
			end
		end
	end

	assign done   = scanning && ((kind_q == KIND_CLEAR) || cmp_match || !more);
	assign finish = done && (!out_valid_q || rsp.ready);
	assign issue  = scanning && (kind_q != KIND_CLEAR) && !cmp_match && more;

	always_comb begin
		hit_d   = 1'b0;
		data_d  = '0;
		wr      = '0;
		wr_addr = cmp_match ? cmp_idx_q : cnt_q[IDX_W-1:0];
		wr.entry.key   = id_q;
		wr.entry.value = value_q;
		wr.entry.mark  = {1'b1, flags_q};
		case (kind_q)
			KIND_CLEAR: begin
				hit_d = 1'b1;
			end
			KIND_REG: begin
				hit_d = cmp_match || room;
				if (finish && hit_d) begin
					wr.kv_en   = 1'b1;
					wr.mark_en = 1'b1;
				end
			end
			KIND_UNREG: begin
				hit_d = cmp_match;
				wr.entry.mark = '0;
				wr.mark_en    = finish && cmp_match;
			end
			KIND_LOOKUP: begin
				hit_d  = cmp_match;
				data_d = cmp_match ? rd_data.value : '0;
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	idkht_slot_mem #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_slot_mem (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_SCAN;
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q     <= idx_q + CNT_W'(1);
						cmp_vld_q <= 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_CLEAR) begin
							cnt_q <= '0;
						end else if (kind_q == KIND_REG && !cmp_match && room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			id_q    <= req.id;
			value_q <= req.value;
			flags_q <= req.flags;
		end
		if (issue) begin
			cmp_idx_q <= idx_q[IDX_W-1:0];
		end
		if (finish) begin
			hit_q  <= hit_d;
			data_q <= data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.hit   = hit_q;
	assign rsp.data  = data_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOT_COUNT))
		else $error("in-use count above slot count");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scanning |-> (idx_q <= cnt_q))
		else $error("scan index past in-use count");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(cnt_q))
		else $error("in-use count changed while idle");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(scanning))
		else $error("response raised without a finished scan");

endmodule
